// File: src/tbsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tbsi_pkg;
    localparam int TableDepth = 16384;
    localparam int CountWidth = 24;
    localparam int MaxGrid    = 2048;

    typedef enum logic [1:0] {
        OP_COUNT   = 2'd0,
        OP_SCAN    = 2'd1,
        OP_SCATTER = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_GRID_EXTENT = 3'd0,
        CFG_KERNEL_HALF = 3'd1,
        CFG_ORIGIN_U    = 3'd2,
        CFG_ORIGIN_V    = 3'd3,
        CFG_TILE_W_LOG2 = 3'd4,
        CFG_TILE_H_LOG2 = 3'd5,
        CFG_TILES_ROW   = 3'd6,
        CFG_TILES_USE   = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GEO,
        ST_TILE,
        ST_RD,
        ST_RDW,
        ST_WR,
        ST_SWEEP_RD,
        ST_SWEEP_WAIT,
        ST_SWEEP_WR,
        ST_OUT,
        ST_HOLD
    } state_t;

    // Point footprint geometry handed from the geometry unit to the sequencer.
    typedef struct packed {
        logic                skip;
        logic signed [21:0]  u0;
        logic signed [21:0]  v0;
        logic [1:0]          nu;
        logic [1:0]          nv;
    } geo_t;
endpackage
`default_nettype wire

// File: src/tbsi_geometry.sv
`timescale 1ns / 1ps
`default_nettype none
module tbsi_geometry #(
    parameter int MAX_GRID = tbsi_pkg::MaxGrid
) (
    input  wire logic               aclk,
    input  wire logic               start,
    input  wire logic signed [20:0] pos_u,
    input  wire logic signed [20:0] pos_v,
    input  wire logic [11:0]        grid_extent,
    input  wire logic [2:0]         kernel_half_width,
    input  wire logic signed [7:0]  origin_u,
    input  wire logic signed [7:0]  origin_v,
    input  wire logic [2:0]         lw_cfg,
    input  wire logic [2:0]         lh_cfg,
    output tbsi_pkg::geo_t          geo
);
    import tbsi_pkg::*;

    logic signed [21:0] gu, gv, ru, rv, lo_u, hi_u, lo_v, hi_v, su1, sv1;
    logic signed [21:0] ext, s;
    logic [2:0]         lw, lh;
    logic signed [21:0] u0, v0, u1, v1;
    geo_t               geo_reg;

    function automatic logic signed [21:0] rnd(input logic signed [20:0] p);
        logic signed [21:0] a;
        logic [21:0] m;
        begin
            a = {p[20], p};
            m = a[21] ? (-a) : a;
            m = (m + 22'd128) >> 8;
            rnd = a[21] ? -$signed(m) : $signed(m);
        end
    endfunction

    always_comb begin
        if ({10'd0, grid_extent} > 22'(MAX_GRID)) ext = 22'(MAX_GRID);
        else ext = {10'd0, grid_extent};
        s  = {19'd0, kernel_half_width};
        lw = (lw_cfg < 3'd4) ? 3'd4 : lw_cfg;
        lh = (lh_cfg < 3'd4) ? 3'd4 : lh_cfg;
        gu = rnd(pos_u) + (ext >>> 1);
        gv = rnd(pos_v) + (ext >>> 1);
        ru = gu - 22'(origin_u);
        rv = gv - 22'(origin_v);
        lo_u = ru - s;
        hi_u = ru + s;
        lo_v = rv - s;
        hi_v = rv + s;
        // floor by arithmetic shift; ceiling of (hi+1) = floor(hi)+1
        u0 = lo_u >>> lw;
        v0 = lo_v >>> lh;
        u1 = (hi_u >>> lw) + 22'sd1;
        v1 = (hi_v >>> lh) + 22'sd1;
        su1 = u1 - u0;
        sv1 = v1 - v0;
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            geo_reg.skip <= (gu - s < 0) || (gu + s >= ext) || (gv - s < 0) || (gv + s >= ext);
            geo_reg.u0 <= u0;
            geo_reg.v0 <= v0;
            geo_reg.nu <= (su1 > 22'sd1) ? 2'd2 : 2'd1;
            geo_reg.nv <= (sv1 > 22'sd1) ? 2'd2 : 2'd1;
        end
    end
    assign geo = geo_reg;
endmodule
`default_nettype wire

// File: src/tbsi_table.sv
`timescale 1ns / 1ps
`default_nettype none
module tbsi_table #(
    parameter int TABLE_DEPTH = tbsi_pkg::TableDepth,
    parameter int COUNT_WIDTH = tbsi_pkg::CountWidth,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  wire logic                   aclk,
    input  wire logic                   we,
    input  wire logic [AW-1:0]          waddr,
    input  wire logic [COUNT_WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]          raddr,
    output logic [COUNT_WIDTH-1:0]      rdata
);
    logic [COUNT_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end
    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// File: src/tile_bucket_sort_indexer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake           Payload
// s_axis    in         s_tvalid/s_tready   tdata: operation, pos_u, pos_v, visibility_id
// m_axis    out        m_tvalid/m_tready   tdata: tile_number, slot, placed_id; tuser: skip, drop
// cfg       in         cfg_we              cfg_index, cfg_data
// Sequence: one item at a time; a count or scatter steps through accept, geometry,
// then per tile address, read, wait, write, load, present; a dropped tile goes from
// address to load, and a skipped point from geometry to load. A scan or clear walks
// tiles_in_use entries (read, wait, write each) through the table, then load and
// present. Reset clears all TABLE_DEPTH entries the same way before s_tready rises.
// A stalled m_tready holds the sequencer on the present cycle; s_tready is low while busy.
module tile_bucket_sort_indexer_core #(
    parameter int TABLE_DEPTH = tbsi_pkg::TableDepth,
    parameter int COUNT_WIDTH = tbsi_pkg::CountWidth,
    parameter int MAX_GRID    = tbsi_pkg::MaxGrid,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,  // operation, pos_u, pos_v, visibility_id, zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,  // tile_number, slot, placed_id, zero pad
    output logic [1:0]       m_tuser,  // point_skipped, tile_dropped
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [14:0] cfg_data
);
    import tbsi_pkg::*;

    // configuration
    logic [11:0] grid_reg;
    logic [2:0]  khw_reg, lw_reg, lh_reg;
    logic signed [7:0] ou_reg, ov_reg;
    logic [8:0]  tpr_reg;
    logic [14:0] tiu_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_reg <= 12'd2048; khw_reg <= 3'd3; ou_reg <= -8'sd16; ov_reg <= -8'sd8;
            lw_reg <= 3'd5; lh_reg <= 3'd4; tpr_reg <= 9'd64; tiu_reg <= 15'd8192;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GRID_EXTENT: grid_reg <= cfg_data[11:0];
                CFG_KERNEL_HALF: khw_reg  <= cfg_data[2:0];
                CFG_ORIGIN_U:    ou_reg   <= cfg_data[7:0];
                CFG_ORIGIN_V:    ov_reg   <= cfg_data[7:0];
                CFG_TILE_W_LOG2: lw_reg   <= cfg_data[2:0];
                CFG_TILE_H_LOG2: lh_reg   <= cfg_data[2:0];
                CFG_TILES_ROW:   tpr_reg  <= cfg_data[8:0];
                CFG_TILES_USE:   tiu_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [16:0] n_use;
    always_comb begin
        if ({2'd0, tiu_reg} > 17'(TABLE_DEPTH)) n_use = 17'(TABLE_DEPTH);
        else n_use = {2'd0, tiu_reg};
    end

    // sequencer
    state_t state_reg, state_next;
    op_t    op_reg;
    logic [23:0] id_reg;
    logic [1:0]  iu_reg, iv_reg;
    logic [AW:0] sweep_reg;   // one extra bit to reach the depth
    logic        init_reg;
    logic [COUNT_WIDTH-1:0] sum_reg;
    logic [31:0] skipped_reg;
    logic [AW-1:0] addr_reg;
    logic        last_tile;
    geo_t        geo;

    logic [13:0] o_tile_reg;
    logic [23:0] o_slot_reg, o_id_reg;
    logic        o_skip_reg, o_drop_reg, o_last_reg, o_valid_reg;

    logic signed [22:0] pu, pv;
    logic signed [32:0] tn;
    logic drop;
    logic [COUNT_WIDTH-1:0] rdata;
    logic we;
    logic [AW-1:0] waddr;
    logic [COUNT_WIDTH-1:0] wdata;
    logic [AW-1:0] raddr;

    tbsi_geometry #(.MAX_GRID(MAX_GRID)) u_geo (
        .aclk(aclk), .start(s_tvalid && s_tready),
        .pos_u(s_tdata[22:2]), .pos_v(s_tdata[43:23]),
        .grid_extent(grid_reg), .kernel_half_width(khw_reg),
        .origin_u(ou_reg), .origin_v(ov_reg), .lw_cfg(lw_reg), .lh_cfg(lh_reg),
        .geo(geo)
    );

    tbsi_table #(.TABLE_DEPTH(TABLE_DEPTH), .COUNT_WIDTH(COUNT_WIDTH)) u_tab (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    // tile coordinate and row-major number of the current footprint step
    always_comb begin
        pu = 23'(geo.u0) + 23'(signed'({1'b0, iu_reg}));
        pv = 23'(geo.v0) + 23'(signed'({1'b0, iv_reg}));
        tn = 33'(pv) * 33'(signed'({1'b0, tpr_reg})) + 33'(pu);
        drop = (pu < 0) || (pu >= 23'(signed'({1'b0, tpr_reg}))) || (pv < 0) ||
               (tn < 0) || (tn >= 33'(signed'({1'b0, n_use})));
        last_tile = (iu_reg + 2'd1 >= geo.nu) && (iv_reg + 2'd1 >= geo.nv);
    end

    always_comb begin
        we = 1'b0;
        waddr = addr_reg;
        wdata = '0;
        raddr = addr_reg;
        if (state_reg == ST_WR) begin
            we = 1'b1;
            wdata = rdata + COUNT_WIDTH'(1);
        end else if (state_reg == ST_SWEEP_WR) begin
            we = 1'b1;
            wdata = (op_reg == OP_SCAN && !init_reg) ? sum_reg : '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) begin
                if (s_tdata[1:0] == OP_SCAN || s_tdata[1:0] == OP_CLEAR)
                    state_next = (n_use == 17'd0) ? ST_OUT : ST_SWEEP_RD;
                else state_next = ST_GEO;
            end
            ST_GEO:        state_next = geo.skip ? ST_OUT : ST_TILE;
            ST_TILE:       state_next = drop ? ST_OUT : ST_RD;
            ST_RD:         state_next = ST_RDW;
            ST_RDW:        state_next = ST_WR;
            ST_WR:         state_next = ST_OUT;
            ST_SWEEP_RD:   state_next = ST_SWEEP_WAIT;
            ST_SWEEP_WAIT: state_next = ST_SWEEP_WR;
            ST_SWEEP_WR: begin
                if (init_reg)
                    state_next = (sweep_reg + 1'b1 >= (AW+1)'(TABLE_DEPTH)) ? ST_IDLE : ST_SWEEP_RD;
                else
                    state_next = ({{(17-AW-1){1'b0}}, sweep_reg} + 17'd1 >= n_use) ? ST_OUT
                                                                                   : ST_SWEEP_RD;
            end
            ST_OUT:  state_next = ST_HOLD;
            ST_HOLD: if (!o_valid_reg || m_tready)
                         state_next = o_last_reg ? ST_IDLE : ST_TILE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE) && !init_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP_RD;
            init_reg <= 1'b1;
            sweep_reg <= '0;
            skipped_reg <= '0;
            o_valid_reg <= 1'b0;
            iu_reg <= '0; iv_reg <= '0;
            addr_reg <= '0;
            sum_reg <= '0;
            op_reg <= OP_COUNT;
        end else begin
            state_reg <= state_next;
            if (o_valid_reg && m_tready) o_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (s_tvalid && s_tready) begin
                    op_reg <= op_t'(s_tdata[1:0]);
                    id_reg <= s_tdata[67:44];
                    iu_reg <= '0; iv_reg <= '0;
                    sweep_reg <= '0; sum_reg <= '0; addr_reg <= '0;
                end
                ST_GEO: if (geo.skip && op_reg == OP_COUNT) skipped_reg <= skipped_reg + 32'd1;
                ST_TILE: addr_reg <= tn[AW-1:0];
                ST_SWEEP_WR: begin
                    if (op_reg == OP_SCAN && !init_reg) sum_reg <= sum_reg + rdata;
                    sweep_reg <= sweep_reg + 1'b1;
                    addr_reg <= addr_reg + 1'b1;
                    if (init_reg && sweep_reg + 1'b1 >= (AW+1)'(TABLE_DEPTH)) init_reg <= 1'b0;
                end
                ST_HOLD: if ((!o_valid_reg || m_tready) && !o_last_reg) begin
                    // advance u then v over the footprint
                    if (iu_reg + 2'd1 >= geo.nu) begin
                        iu_reg <= '0; iv_reg <= iv_reg + 2'd1;
                    end else iu_reg <= iu_reg + 2'd1;
                end
                default: ;
            endcase
            if (state_reg == ST_OUT) o_valid_reg <= 1'b1;
        end
    end

    // load result register when entering ST_OUT
    always_ff @(posedge aclk) begin
        if (state_next == ST_OUT && state_reg != ST_OUT) begin
            o_tile_reg <= '0; o_slot_reg <= '0; o_id_reg <= '0;
            o_skip_reg <= 1'b0; o_drop_reg <= 1'b0; o_last_reg <= 1'b1;
            if (state_reg == ST_IDLE || state_reg == ST_SWEEP_WR) begin
                if (op_reg == OP_SCAN && state_reg == ST_SWEEP_WR)
                    o_slot_reg <= 24'(sum_reg + rdata);
            end else if (state_reg == ST_GEO) begin
                o_skip_reg <= 1'b1;
            end else if (state_reg == ST_TILE) begin
                o_drop_reg <= 1'b1;
                o_last_reg <= last_tile;
            end else begin
                o_tile_reg <= 14'(addr_reg);
                o_slot_reg <= 24'(rdata);
                o_id_reg <= (op_reg == OP_SCATTER) ? id_reg : 24'd0;
                o_last_reg <= last_tile;
            end
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {2'd0, o_id_reg, o_slot_reg, o_tile_reg};
    assign m_tuser  = {o_drop_reg, o_skip_reg};
    assign m_tlast  = o_last_reg;
endmodule
`default_nettype wire

// File: src/tbsi_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module tbsi_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [1:0] m_tuser,
    input wire logic [63:0] m_tdata,
    input wire logic m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted during work");
    a_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == 64'd0)
        else $error("skip result malformed");
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == 64'd0 && !m_tuser[0])
        else $error("drop result malformed");
endmodule

bind tile_bucket_sort_indexer_core tbsi_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser),
    .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
